/* rtl/sas_pkg.sv */
// Shared types and constants of the sprite animation sequencer.
package sas_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CHANGE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_ORIENT = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_UNKNOWN = 2'd2,
    STATUS_NO_ANIM = 2'd3
  } status_e;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP  = 1'b1;

  localparam logic [7:0] TILE_WIDTH_RST = 8'd16;
  localparam logic [3:0] FRAME_GAP_RST  = 4'd0;

  localparam logic [23:0] TIMER_MAX = 24'hFF_FFFF;

  // Table entry, geometry half.
  typedef struct packed {
    logic [7:0]  loop_start;
    logic [7:0]  frames_in_anim;
    logic [11:0] start_y;
    logic [11:0] start_x;
  } geo_t;

  // Table entry, timing half.
  typedef struct packed {
    logic        runs_when_still;
    logic [1:0]  drawn_facing;
    logic [23:0] frame_time;
  } tim_t;

  // Controller to datapath.
  typedef struct packed {
    logic ready;
    logic exec;
    logic srch_start;
    logic srch_rd;
    logic srch_next;
    logic srch_hit;
    logic srch_miss;
    logic fetch;
    logic eval;
    logic mul;
    logic load;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_valid;
    logic need_search;
    logic srch_end;
    logic key_hit;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/sas_if.sv */
// Word channels of the sprite animation sequencer: input items and results.
interface sas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  state_id;
  logic [11:0] start_x;
  logic [11:0] start_y;
  logic [7:0]  frames_in_anim;
  logic [23:0] frame_time;
  logic [7:0]  loop_start;
  logic [1:0]  drawn_facing;
  logic        runs_when_still;
  logic [23:0] elapsed;
  logic        is_still;
  logic [1:0]  facing;

  modport source (
    output valid, func, state_id, start_x, start_y, frames_in_anim, frame_time,
           loop_start, drawn_facing, runs_when_still, elapsed, is_still, facing,
    input  ready
  );
  modport sink (
    input  valid, func, state_id, start_x, start_y, frames_in_anim, frame_time,
           loop_start, drawn_facing, runs_when_still, elapsed, is_still, facing,
    output ready
  );
endinterface

interface sas_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] src_x;
  logic [11:0] src_y;
  logic [7:0]  frame_index;
  logic        flip;
  logic [1:0]  status;

  modport source (
    output valid, src_x, src_y, frame_index, flip, status,
    input  ready
  );
  modport sink (
    input  valid, src_x, src_y, frame_index, flip, status,
    output ready
  );
endinterface

/* rtl/sas_ctrl.sv */
// Controller state machine of the sprite animation sequencer.
module sas_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sas_pkg::dp_stat_t   stat_i,
  output sas_pkg::ctl_cmd_t   cmd_o
);
  import sas_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_EXEC     = 8'b0000_0010,
    ST_SRCH_RD  = 8'b0000_0100,
    ST_SRCH_CMP = 8'b0000_1000,
    ST_FETCH    = 8'b0001_0000,
    ST_EVAL     = 8'b0010_0000,
    ST_MUL      = 8'b0100_0000,
    ST_LOAD     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.ready = 1'b1;
        if (stat_i.in_valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec       = 1'b1;
        cmd_o.srch_start = 1'b1;
        state_d = stat_i.need_search ? ST_SRCH_RD : ST_FETCH;
      end
      ST_SRCH_RD: begin
        if (stat_i.srch_end) begin
          cmd_o.srch_miss = 1'b1;
          state_d = ST_FETCH;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (stat_i.key_hit) begin
          cmd_o.srch_hit = 1'b1;
          state_d = ST_FETCH;
        end else begin
          cmd_o.srch_next = 1'b1;
          state_d = ST_SRCH_RD;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // result register must be free when a result is loaded
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> stat_i.out_free)
    else $error("result loaded over a pending word");

  // a key compare always follows its read
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH_CMP) |-> ($past(state_q) == ST_SRCH_RD))
    else $error("key compare without a read");

  // a hit ends the search and fetches the entry
  a_hit_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.srch_hit |=> (state_q == ST_FETCH))
    else $error("hit did not fetch the entry");

endmodule

/* rtl/sas_dp.sv */
// Datapath of the sprite animation sequencer: table memories, timer, frame, result.
module sas_dp #(
  parameter int unsigned MAX_ANIMS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sas_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sas_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  sas_in_if.sink                            in_i,
  sas_out_if.source                         out_o,
  input  sas_pkg::ctl_cmd_t                 cmd_i,
  output sas_pkg::dp_stat_t                 stat_o
);
  import sas_pkg::*;

  localparam int unsigned IDX_W = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ANIMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ANIMS);

  // table memories
  logic [7:0] key_mem [MAX_ANIMS];
  geo_t       geo_mem [MAX_ANIMS];
  tim_t       tim_mem [MAX_ANIMS];
  logic [7:0] key_rd_q;
  geo_t       geo_rd_q;
  tim_t       tim_rd_q;

  // latched item
  func_e       func_q;
  logic [7:0]  sid_q;
  geo_t        geo_in_q;
  tim_t        tim_in_q;
  logic [23:0] elapsed_q;
  logic        is_still_q;
  logic [1:0]  facing_in_q;

  // configuration
  logic [7:0] tile_width_q;
  logic [3:0] frame_gap_q;

  // sequencer state
  logic [CNT_W-1:0] anim_count_q;
  logic [IDX_W-1:0] active_entry_q;
  logic             has_active_q;
  logic [7:0]       active_sid_q;
  logic [7:0]       frame_q, frame_d;
  logic [23:0]      timer_q, timer_d;
  logic [1:0]       cur_facing_q;
  logic [CNT_W-1:0] srch_idx_q;
  status_e          status_q;
  logic [16:0]      prod_q;

  // result register
  logic        out_valid_q;
  logic [16:0] src_x_q;
  logic [11:0] src_y_q;
  logic [7:0]  frame_index_q;
  logic        flip_q;
  status_e     out_status_q;

  logic             accept;
  logic             full;
  logic             add_ok;
  logic [IDX_W-1:0] rd_addr;
  logic [24:0]      tsum;
  logic [23:0]      tsat;
  logic [8:0]       fnext;
  logic             tick_run;
  logic [17:0]      xsum;

  assign accept = cmd_i.ready & in_i.valid;
  assign full   = (anim_count_q == CNT_MAX);
  assign add_ok = cmd_i.exec & (func_q == FUNC_ADD) & ~full;
  assign rd_addr = cmd_i.srch_rd ? srch_idx_q[IDX_W-1:0] : active_entry_q;

  assign in_i.ready = cmd_i.ready;

  assign stat_o.in_valid    = in_i.valid;
  assign stat_o.need_search = (func_q == FUNC_CHANGE) & (sid_q != active_sid_q);
  assign stat_o.srch_end    = (srch_idx_q >= anim_count_q);
  assign stat_o.key_hit     = (key_rd_q == sid_q);
  assign stat_o.out_free    = ~out_valid_q | out_o.ready;

  // tick: saturating timer, advance and wrap
  always_comb begin
    tsum     = {1'b0, timer_q} + {1'b0, elapsed_q};
    tsat     = tsum[24] ? TIMER_MAX : tsum[23:0];
    fnext    = {1'b0, frame_q} + 9'd1;
    tick_run = (func_q == FUNC_TICK) & has_active_q &
               ~(is_still_q & ~tim_rd_q.runs_when_still);
    timer_d  = timer_q;
    frame_d  = frame_q;
    if (tick_run) begin
      if (tsat > tim_rd_q.frame_time) begin
        timer_d = '0;
        frame_d = (fnext >= {1'b0, geo_rd_q.frames_in_anim}) ?
                  geo_rd_q.loop_start : fnext[7:0];
      end else begin
        timer_d = tsat;
      end
    end
  end

  assign xsum = {6'd0, geo_rd_q.start_x} + {1'b0, prod_q};

  // memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      key_mem[anim_count_q[IDX_W-1:0]] <= sid_q;
      geo_mem[anim_count_q[IDX_W-1:0]] <= geo_in_q;
      tim_mem[anim_count_q[IDX_W-1:0]] <= tim_in_q;
    end
    if (cmd_i.srch_rd | cmd_i.fetch) begin
      key_rd_q <= key_mem[rd_addr];
      geo_rd_q <= geo_mem[rd_addr];
      tim_rd_q <= tim_mem[rd_addr];
    end
  end

  // item capture and product
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= func_e'(in_i.func);
      sid_q       <= in_i.state_id;
      geo_in_q    <= '{loop_start: in_i.loop_start, frames_in_anim: in_i.frames_in_anim,
                       start_y: in_i.start_y, start_x: in_i.start_x};
      tim_in_q    <= '{runs_when_still: in_i.runs_when_still,
                       drawn_facing: in_i.drawn_facing, frame_time: in_i.frame_time};
      elapsed_q   <= in_i.elapsed;
      is_still_q  <= in_i.is_still;
      facing_in_q <= in_i.facing;
    end
    if (cmd_i.srch_start) srch_idx_q <= '0;
    else if (cmd_i.srch_next) srch_idx_q <= srch_idx_q + CNT_W'(1);
    if (cmd_i.mul) prod_q <= 17'(frame_q) * (17'(tile_width_q) + 17'(frame_gap_q));
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_width_q <= TILE_WIDTH_RST;
      frame_gap_q  <= FRAME_GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TILE_WIDTH: tile_width_q <= cfg_data_i;
        CFG_FRAME_GAP:  frame_gap_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anim_count_q   <= '0;
      active_entry_q <= '0;
      has_active_q   <= 1'b0;
      active_sid_q   <= '0;
      frame_q        <= '0;
      timer_q        <= '0;
      cur_facing_q   <= '0;
      status_q       <= STATUS_OK;
    end else begin
      if (accept) status_q <= STATUS_OK;
      if (cmd_i.exec) begin
        if (func_q == FUNC_ADD) begin
          if (full) begin
            status_q <= STATUS_FULL;
          end else begin
            anim_count_q <= anim_count_q + CNT_W'(1);
            if (!has_active_q) begin
              active_entry_q <= '0;
              has_active_q   <= 1'b1;
            end
          end
        end
        if (func_q == FUNC_ORIENT) cur_facing_q <= facing_in_q;
      end
      if (cmd_i.srch_miss) status_q <= STATUS_UNKNOWN;
      if (cmd_i.srch_hit) begin
        active_sid_q   <= sid_q;
        active_entry_q <= srch_idx_q[IDX_W-1:0];
        has_active_q   <= 1'b1;
        if (!has_active_q || (srch_idx_q[IDX_W-1:0] != active_entry_q)) begin
          frame_q <= '0;
          timer_q <= '0;
        end
      end
      if (cmd_i.eval) begin
        frame_q <= frame_d;
        timer_q <= timer_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (has_active_q) begin
        src_x_q       <= xsum[16:0];
        src_y_q       <= geo_rd_q.start_y;
        frame_index_q <= frame_q;
        flip_q        <= (cur_facing_q != 2'd0) & (cur_facing_q != tim_rd_q.drawn_facing);
        out_status_q  <= status_q;
      end else begin
        src_x_q       <= '0;
        src_y_q       <= '0;
        frame_index_q <= '0;
        flip_q        <= 1'b0;
        out_status_q  <= (status_q == STATUS_OK) ? STATUS_NO_ANIM : status_q;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.src_x       = src_x_q;
  assign out_o.src_y       = src_y_q;
  assign out_o.frame_index = frame_index_q;
  assign out_o.flip        = flip_q;
  assign out_o.status      = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    anim_count_q <= CNT_MAX)
    else $error("table count past capacity");

  a_active_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_active_q |-> (anim_count_q != '0))
    else $error("active entry in an empty table");

  a_active_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_active_q |-> ({{(CNT_W-IDX_W+1){1'b0}}, active_entry_q} < {1'b0, anim_count_q}))
    else $error("active entry never written");

endmodule

/* rtl/sprite_animation_sequencer.sv */
// Top level of the sprite animation sequencer: controller plus datapath.
//
// Use: input words arrive on in_i (valid/ready), one result word per input
// word leaves on out_o (valid/ready). func selects add animation, change
// state, tick or set orientation. The tile width and frame gap registers are
// written on the cfg port (index 0 and 1); the user must write them only
// while the block is idle, which the block itself does not enforce.
// Timing: an input word is taken only when the sequencer is idle. A word
// then takes EXEC, FETCH, EVAL, MUL and LOAD, and the next word is taken
// only once the sequencer is back in IDLE. A change to a new state id walks
// the key memory with a SRCH_RD and a SRCH_CMP per entry inspected, ending on
// a hit or in SRCH_RD past the fill count. The single read port of the table
// memories sets this walk; MUL holds the frame_index*(width+gap) product.
// The result word enters the result register in LOAD, after any key walk of
// a change. The result register sits between the sides: while a result waits
// for out_o.ready the next word is already accepted and worked on; it stalls
// only in LOAD until the waiting result is taken.
// Reset: table empty, no active animation, frame, timer and facing zero,
// tile width 16, frame gap 0. Table memories need no clearing pass; only
// entries below the fill count are used.
module sprite_animation_sequencer #(
  parameter int unsigned MAX_ANIMS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sas_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sas_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  sas_in_if.sink                          in_i,
  sas_out_if.source                       out_o
);
  import sas_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // state machine: sequences one word at a time
  sas_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // table, timer, frame counter and result register
  sas_dp #(
    .MAX_ANIMS (MAX_ANIMS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for the sprite animation sequencer: directed table, then random phases.
module testbench;
  import sas_pkg::*;

  // Geometry of the run.
  localparam int unsigned TABLE_DEPTH     = 16;
  localparam int unsigned ITEMS_PER_PHASE = 400;
  localparam int unsigned PHASES          = 5;
  // Slowest word: EXEC to LOAD plus a full key walk, plus sender gaps and
  // receiver stall bursts that may chain. QUIET_LIMIT silent cycles mean a hang.
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES    = 2 * TABLE_DEPTH + 16;

  // One input word, field by field as the in channel carries it.
  typedef struct packed {
    func_e       func;
    logic [7:0]  state_id;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [7:0]  frames_in_anim;
    logic [23:0] frame_time;
    logic [7:0]  loop_start;
    logic [1:0]  drawn_facing;
    logic        runs_when_still;
    logic [23:0] elapsed;
    logic        is_still;
    logic [1:0]  facing;
  } word_t;

  localparam int unsigned WORD_BITS = $bits(word_t);

  // One result word.
  typedef struct packed {
    logic [16:0] src_x;
    logic [11:0] src_y;
    logic [7:0]  frame_index;
    logic        flip;
    status_e     status;
  } frame_t;

  // A row of the directed table. Rows with typed set carry their result
  // written out by hand; the rest are left to the predictor.
  typedef struct {
    word_t       w;
    int unsigned reps;
    bit          typed;
    frame_t      want;
  } row_t;

  localparam frame_t BLANK = '{17'd0, 12'd0, 8'd0, 1'b0, STATUS_NO_ANIM};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sas_in_if  in_ch ();
  sas_out_if out_ch ();

  sprite_animation_sequencer #(
    .MAX_ANIMS (TABLE_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: animation table, active entry, frame/timer, facing and
  // the two settings. Values here are the post-reset values.
  // ---------------------------------------------------------------------------
  logic [7:0]  key_mem [TABLE_DEPTH];
  geo_t        geo_mem [TABLE_DEPTH];
  tim_t        tim_mem [TABLE_DEPTH];
  int unsigned fill_count = 0;
  logic [3:0]  cur_entry  = '0;
  logic        cur_valid  = 1'b0;
  logic [7:0]  cur_id     = '0;
  logic [7:0]  cur_frame  = '0;
  logic [23:0] cur_timer  = '0;
  logic [1:0]  cur_facing = '0;
  logic [7:0]  width_reg  = TILE_WIDTH_RST;
  logic [3:0]  gap_reg    = FRAME_GAP_RST;

  frame_t      frames_due [$];   // results still owed by the block, oldest first
  row_t        plan [$];         // directed table
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct      = 25; // chance of a sender gap before a word
  int unsigned stall_pct    = 25; // chance per cycle of a receiver stall burst

  // Apply one word to the predictor state and return the result it yields.
  function automatic frame_t animate(input word_t w);
    frame_t      r;
    status_e     st;
    logic [24:0] sum;
    logic [8:0]  nxt;
    int          hit;
    logic [16:0] pitch;
    st  = STATUS_OK;
    hit = -1;
    case (w.func)
      FUNC_ADD: begin
        if (fill_count >= TABLE_DEPTH) begin
          st = STATUS_FULL;
        end else begin
          key_mem[fill_count] = w.state_id;
          geo_mem[fill_count] = '{loop_start: w.loop_start, frames_in_anim: w.frames_in_anim,
                                  start_y: w.start_y, start_x: w.start_x};
          tim_mem[fill_count] = '{runs_when_still: w.runs_when_still,
                                  drawn_facing: w.drawn_facing, frame_time: w.frame_time};
          fill_count++;
          // first entry ever goes active; frame, timer and id are untouched
          if (!cur_valid) begin
            cur_entry = '0;
            cur_valid = 1'b1;
          end
        end
      end
      FUNC_CHANGE: begin
        // a change to the id already held is a no-op, even with no entry active
        if (w.state_id != cur_id) begin
          for (int i = 0; i < int'(fill_count); i++) begin
            if (hit < 0 && key_mem[i] == w.state_id) hit = i;
          end
          if (hit < 0) begin
            st = STATUS_UNKNOWN;
          end else begin
            cur_id = w.state_id;
            // restart only when the entry really changes
            if (!cur_valid || hit != int'(cur_entry)) begin
              cur_frame = '0;
              cur_timer = '0;
            end
            cur_entry = 4'(hit);
            cur_valid = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        if (!cur_valid) begin
          st = STATUS_NO_ANIM;
        end else if (!(w.is_still && !tim_mem[cur_entry].runs_when_still)) begin
          sum       = {1'b0, cur_timer} + {1'b0, w.elapsed};
          cur_timer = sum[24] ? TIMER_MAX : sum[23:0];
          if (cur_timer > tim_mem[cur_entry].frame_time) begin
            cur_timer = '0;
            // 9-bit compare so frame 255 + 1 still wraps
            nxt = {1'b0, cur_frame} + 9'd1;
            if (nxt >= {1'b0, geo_mem[cur_entry].frames_in_anim}) begin
              nxt = {1'b0, geo_mem[cur_entry].loop_start};
            end
            cur_frame = nxt[7:0];
          end
        end
      end
      default: begin
        cur_facing = w.facing;
      end
    endcase
    if (cur_valid) begin
      pitch         = 17'(width_reg) + 17'(gap_reg);
      r.src_x       = 17'(geo_mem[cur_entry].start_x) + 17'(cur_frame) * pitch;
      r.src_y       = geo_mem[cur_entry].start_y;
      r.frame_index = cur_frame;
      r.flip        = (cur_facing != 2'd0) && (cur_facing != tim_mem[cur_entry].drawn_facing);
      r.status      = st;
    end else begin
      r        = BLANK;
      r.status = (st == STATUS_OK) ? STATUS_NO_ANIM : st;
    end
    return r;
  endfunction

  // Word builders for the directed table.
  function automatic word_t anim_add(input logic [7:0] sid, input logic [11:0] x,
                                     input logic [11:0] y, input logic [7:0] n,
                                     input logic [23:0] ft, input logic [7:0] lp,
                                     input logic [1:0] drawn, input logic runs);
    word_t w;
    w                 = '0;
    w.func            = FUNC_ADD;
    w.state_id        = sid;
    w.start_x         = x;
    w.start_y         = y;
    w.frames_in_anim  = n;
    w.frame_time      = ft;
    w.loop_start      = lp;
    w.drawn_facing    = drawn;
    w.runs_when_still = runs;
    return w;
  endfunction

  function automatic word_t anim_tick(input logic [23:0] el, input logic idle);
    word_t w;
    w          = '0;
    w.func     = FUNC_TICK;
    w.elapsed  = el;
    w.is_still = idle;
    return w;
  endfunction

  function automatic word_t anim_cmd(input func_e func, input logic [7:0] sid,
                                     input logic [1:0] face);
    word_t w;
    w          = '0;
    w.func     = func;
    w.state_id = sid;
    w.facing   = face;
    return w;
  endfunction

  task automatic plan_row(input word_t w, input int unsigned reps = 1,
                          input bit typed = 1'b0, input frame_t want = BLANK);
    plan.push_back('{w, reps, typed, want});
  endtask

  // Random word: every field gets random bits, then the mix is shaped so that
  // ticks and changes dominate and changes mostly hit keys in the table.
  function automatic word_t random_word();
    word_t       w;
    int unsigned pick;
    w    = word_t'(WORD_BITS'({$urandom, $urandom, $urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 8)       w.func = FUNC_ADD;
    else if (pick < 38) w.func = FUNC_CHANGE;
    else if (pick < 88) w.func = FUNC_TICK;
    else                w.func = FUNC_ORIENT;
    case (w.func)
      FUNC_CHANGE: begin
        if (fill_count != 0 && $urandom_range(0, 99) < 85) begin
          w.state_id = key_mem[$urandom_range(0, fill_count - 1)];
        end
      end
      FUNC_TICK: begin
        case ($urandom_range(0, 9))
          0:       w.elapsed = '0;
          1:       w.elapsed = TIMER_MAX;
          2, 3:    ;
          default: w.elapsed = 24'($urandom_range(0, 24'h04_0000));
        endcase
        w.is_still = ($urandom_range(0, 3) == 0);
      end
      default: ;
    endcase
    return w;
  endfunction

  // Present one word from a falling edge, hold it until taken, then log what
  // the block owes for it.
  task automatic send_word(input word_t w, input bit typed, input frame_t want);
    frame_t got;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_ch.func            = w.func;
    in_ch.state_id        = w.state_id;
    in_ch.start_x         = w.start_x;
    in_ch.start_y         = w.start_y;
    in_ch.frames_in_anim  = w.frames_in_anim;
    in_ch.frame_time      = w.frame_time;
    in_ch.loop_start      = w.loop_start;
    in_ch.drawn_facing    = w.drawn_facing;
    in_ch.runs_when_still = w.runs_when_still;
    in_ch.elapsed         = w.elapsed;
    in_ch.is_still        = w.is_still;
    in_ch.facing          = w.facing;
    in_ch.valid           = 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    got = animate(w);
    frames_due.push_back(typed ? want : got);
  endtask

  // Settings change only with the block drained.
  task automatic write_settings(input logic [7:0] wid, input logic [3:0] gp);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (frames_due.size() != 0) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CFG_TILE_WIDTH;
    cfg_data_i = wid;
    @(negedge clk_i);
    cfg_idx_i  = CFG_FRAME_GAP;
    cfg_data_i = CFG_DATA_W'(gp);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    width_reg  = wid;
    gap_reg    = gp;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts on ready, compare at the rising edge.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : take_result
    frame_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (frames_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word expected none actual src_x %0d status %0d", $time,
                 out_ch.src_x, out_ch.status);
      end else begin
        want = frames_due.pop_front();
        check_field("src_x", 32'(want.src_x), 32'(out_ch.src_x));
        check_field("src_y", 32'(want.src_y), 32'(out_ch.src_y));
        check_field("frame_index", 32'(want.frame_index), 32'(out_ch.frame_index));
        check_field("flip", 32'(want.flip), 32'(out_ch.flip));
        check_field("status", 32'(want.status), 32'(out_ch.status));
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    word_t       w;
    logic [7:0]  wid;
    logic [3:0]  gp;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_TILE_WIDTH;
    cfg_data_i            = '0;
    in_ch.valid           = 1'b0;
    in_ch.func            = FUNC_ADD;
    in_ch.state_id        = '0;
    in_ch.start_x         = '0;
    in_ch.start_y         = '0;
    in_ch.frames_in_anim  = '0;
    in_ch.frame_time      = '0;
    in_ch.loop_start      = '0;
    in_ch.drawn_facing    = '0;
    in_ch.runs_when_still = 1'b0;
    in_ch.elapsed         = '0;
    in_ch.is_still        = 1'b0;
    in_ch.facing          = '0;

    // Directed table, run at reset settings (width 16, gap 0).
    // Empty table: tick, same-id change, unknown id, orientation.
    plan_row(anim_tick(TIMER_MAX, 1'b0), 1, 1'b1, BLANK);
    plan_row(anim_cmd(FUNC_CHANGE, 8'h00, 2'd0), 1, 1'b1, BLANK);
    plan_row(anim_cmd(FUNC_CHANGE, 8'hFF, 2'd0), 1, 1'b1,
             '{17'd0, 12'd0, 8'd0, 1'b0, STATUS_UNKNOWN});
    plan_row(anim_cmd(FUNC_ORIENT, 8'h00, 2'd2), 1, 1'b1, BLANK);
    // First add goes active right away; facing 2 vs drawn 1 flips.
    plan_row(anim_add(8'h07, 12'hFFF, 12'hFFF, 8'd3, 24'd0, 8'd1, 2'd1, 1'b1), 1, 1'b1,
             '{17'd4095, 12'd4095, 8'd0, 1'b1, STATUS_OK});
    plan_row(anim_tick(24'd1, 1'b0));
    plan_row(anim_tick(24'd0, 1'b0));          // timer equal to frame time: hold
    plan_row(anim_tick(TIMER_MAX, 1'b1));      // still, but this one runs when still
    plan_row(anim_tick(24'd1, 1'b0));          // past the last frame: back to frame 1
    plan_row(anim_cmd(FUNC_CHANGE, 8'h07, 2'd0)); // new id, same entry: keeps frame
    plan_row(anim_add(8'h09, 12'h000, 12'h000, 8'd0, TIMER_MAX, 8'hFF, 2'd2, 1'b0));
    plan_row(anim_cmd(FUNC_CHANGE, 8'h09, 2'd0), 1, 1'b1,
             '{17'd0, 12'd0, 8'd0, 1'b0, STATUS_OK});
    plan_row(anim_tick(TIMER_MAX, 1'b0));
    plan_row(anim_tick(TIMER_MAX, 1'b0));      // timer pinned at max, never advances
    plan_row(anim_tick(24'd5, 1'b1));          // stationary and not allowed: ignored
    plan_row(anim_cmd(FUNC_ORIENT, 8'h00, 2'd0));
    plan_row(anim_add(8'h09, 12'd100, 12'd200, 8'd2, 24'd0, 8'd0, 2'd3, 1'b1)); // dup key
    plan_row(anim_cmd(FUNC_CHANGE, 8'h07, 2'd0));
    plan_row(anim_cmd(FUNC_CHANGE, 8'h07, 2'd0));
    plan_row(anim_cmd(FUNC_CHANGE, 8'h09, 2'd0)); // must pick the first of the two
    plan_row(anim_add(8'h03, 12'hFFF, 12'h000, 8'd0, 24'd0, 8'hFF, 2'd0, 1'b0));
    plan_row(anim_cmd(FUNC_CHANGE, 8'h03, 2'd0));
    plan_row(anim_tick(24'd1, 1'b0));          // zero frames: jumps to frame 255
    plan_row(anim_cmd(FUNC_ORIENT, 8'h00, 2'd3));
    // Fill the rest of the table with random entries, then overflow it.
    plan_row(anim_add(8'h40, 12'h0, 12'h0, 8'd1, 24'd0, 8'd0, 2'd0, 1'b0), TABLE_DEPTH - 4);
    plan_row(anim_add(8'hAA, 12'h123, 12'h456, 8'd5, 24'd9, 8'd2, 2'd1, 1'b1));
    plan_row(anim_cmd(FUNC_CHANGE, 8'h45, 2'd0));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[r]) begin
      for (int unsigned k = 0; k < plan[r].reps; k++) begin
        w = plan[r].w;
        if (plan[r].reps > 1) begin
          // fill entries: short animations with small frame times so ticks move
          w.state_id        = plan[r].w.state_id + 8'(k);
          w.start_x         = 12'($urandom);
          w.start_y         = 12'($urandom);
          w.frames_in_anim  = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(1, 8));
          w.loop_start      = 8'($urandom_range(0, 9));
          w.frame_time      = 24'($urandom_range(0, 24'h03_0000));
          w.drawn_facing    = 2'($urandom);
          w.runs_when_still = 1'($urandom);
        end
        send_word(w, plan[r].typed, plan[r].want);
      end
    end

    // Random phases, each under its own settings and idle pattern. The last
    // one runs with no idling at all.
    for (int p = 0; p < int'(PHASES); p++) begin
      case (p)
        0: begin
          wid = 8'd1;
          gp  = 4'd0;
        end
        1: begin
          wid = 8'd255;
          gp  = 4'd15;
        end
        default: begin
          wid = 8'($urandom_range(1, 255));
          gp  = 4'($urandom);
        end
      endcase
      write_settings(wid, gp);
      case (p)
        0:       begin gap_pct = 25; stall_pct = 25; end
        1:       begin gap_pct = 0;  stall_pct = 40; end
        2:       begin gap_pct = 40; stall_pct = 0;  end
        3:       begin gap_pct = 50; stall_pct = 50; end
        default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      repeat (ITEMS_PER_PHASE) send_word(random_word(), 1'b0, BLANK);
    end

    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sas_pkg.sv
rtl/sas_if.sv
rtl/sas_ctrl.sv
rtl/sas_dp.sv
rtl/sprite_animation_sequencer.sv
tb/sv/testbench.sv
